// File: hdl/lsmb_pkg.sv
// shared types, constants and tables of the laser scan merge binner
package lsmb_pkg;

  localparam int unsigned MaxBinsDefault = 4096;
  localparam int unsigned MaxSamples     = 4096;
  localparam int unsigned CordicSteps    = 14;
  localparam int unsigned CordicW        = 40;
  localparam int unsigned AngW           = 18;
  localparam int unsigned InvGainQ14     = 9949;
  localparam int unsigned InvGainQ16     = 39797;
  localparam int unsigned EmptyMarginMm  = 1000;
  localparam int unsigned CfgIdxW        = 3;
  localparam int unsigned CfgDataW       = 64;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BIN_COUNT   = 3'd0,
    CFG_RANGE_MIN   = 3'd1,
    CFG_RANGE_MAX   = 3'd2,
    CFG_BODY_RADIUS = 3'd3,
    CFG_FRONT_POSE  = 3'd4,
    CFG_BACK_POSE   = 3'd5,
    CFG_FRONT_GEOM  = 3'd6,
    CFG_BACK_GEOM   = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic        filled;
    logic [15:0] min_range;
  } bin_entry_t;

  typedef struct packed {
    logic start;
    logic vec;
  } cordic_ctl_t;

  function automatic logic signed [AngW-1:0] atan_f(input logic [3:0] i);
    logic signed [AngW-1:0] a;
    case (i)
      4'd0:    a = 18'sd8192;
      4'd1:    a = 18'sd4836;
      4'd2:    a = 18'sd2555;
      4'd3:    a = 18'sd1297;
      4'd4:    a = 18'sd651;
      4'd5:    a = 18'sd326;
      4'd6:    a = 18'sd163;
      4'd7:    a = 18'sd81;
      4'd8:    a = 18'sd41;
      4'd9:    a = 18'sd20;
      4'd10:   a = 18'sd10;
      4'd11:   a = 18'sd5;
      4'd12:   a = 18'sd3;
      4'd13:   a = 18'sd1;
      default: a = 18'sd0;
    endcase
    return a;
  endfunction

endpackage

// File: hdl/lsmb_if.sv
// item channels of the laser scan merge binner
interface lsmb_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic        sensor;
  logic [11:0] sample_index;
  logic [15:0] range_mm;
  logic        range_valid;
  logic [11:0] read_bin;

  modport source (output valid, kind, sensor, sample_index, range_mm, range_valid, read_bin,
                  input ready);
  modport sink (input valid, kind, sensor, sample_index, range_mm, range_valid, read_bin,
                output ready);
endinterface

interface lsmb_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] bin_number;
  logic [15:0] bin_range_mm;
  logic        bin_empty;

  modport source (output valid, bin_number, bin_range_mm, bin_empty, input ready);
  modport sink (input valid, bin_number, bin_range_mm, bin_empty, output ready);
endinterface

// File: hdl/lsmb_cordic.sv
// shared iterative cordic unit, rotation and vectoring, one step per cycle
module lsmb_cordic (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  lsmb_pkg::cordic_ctl_t                      ctl_i,
  input  logic signed [lsmb_pkg::CordicW-1:0]        x_i,
  input  logic signed [lsmb_pkg::CordicW-1:0]        y_i,
  input  logic signed [lsmb_pkg::AngW-1:0]           z_i,
  output logic                                       done_o,
  output logic signed [lsmb_pkg::CordicW-1:0]        x_o,
  output logic signed [lsmb_pkg::CordicW-1:0]        y_o,
  output logic signed [lsmb_pkg::AngW-1:0]           z_o
);

  logic signed [lsmb_pkg::CordicW-1:0] x_q, x_d, y_q, y_d;
  logic signed [lsmb_pkg::AngW-1:0]    z_q, z_d;
  logic [3:0]                          step_q;
  logic                                busy_q, vec_q, done_q;
  logic                                pos;

  always_comb begin
    pos = vec_q ? y_q[lsmb_pkg::CordicW-1] : !z_q[lsmb_pkg::AngW-1];
    if (pos) begin
      x_d = x_q - (y_q >>> step_q);
      y_d = y_q + (x_q >>> step_q);
      z_d = z_q - lsmb_pkg::atan_f(step_q);
    end else begin
      x_d = x_q + (y_q >>> step_q);
      y_d = y_q - (x_q >>> step_q);
      z_d = z_q + lsmb_pkg::atan_f(step_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= 4'd0;
      vec_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start) begin
        busy_q <= 1'b1;
        step_q <= 4'd0;
        vec_q  <= ctl_i.vec;
      end else if (busy_q) begin
        step_q <= step_q + 4'd1;
        if (step_q == 4'(lsmb_pkg::CordicSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      x_q <= x_i;
      y_q <= y_i;
      z_q <= z_i;
    end else if (busy_q) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign done_o = done_q;
  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;

endmodule

// File: hdl/lsmb_bin_mem.sv
// bin store: filled flag and minimum range, one write and one registered read port
module lsmb_bin_mem #(
  parameter int unsigned DEPTH = lsmb_pkg::MaxBinsDefault,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                 clk_i,
  input  logic                 rd_en_i,
  input  logic [AW-1:0]        rd_addr_i,
  output lsmb_pkg::bin_entry_t rd_data_o,
  input  logic                 wr_en_i,
  input  logic [AW-1:0]        wr_addr_i,
  input  lsmb_pkg::bin_entry_t wr_data_i
);

  lsmb_pkg::bin_entry_t mem [DEPTH];
  lsmb_pkg::bin_entry_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

// File: hdl/laser_scan_merge_binner.sv
// top level of the laser scan merge binner: control sequencer, pose math, bin update
//
// channel   dir  handshake        payload
// in_i      in   valid / ready    kind, sensor, sample_index, range_mm, range_valid, read_bin
// out_o     out  valid / ready    bin_number, bin_range_mm, bin_empty
// cfg       in   cfg_we_i         cfg_idx_i, cfg_data_i (write only)
//
// a sample takes two 14-step passes of the shared cordic unit
// plus six steps of the single shared multiplier
// a read issues the registered memory read in S_RD and loads the result register in S_RDW
// after reset a clearing pass writes every bin empty, with no item taken
// a read waits in its last step while the previous result has not been taken
module laser_scan_merge_binner #(
  parameter int unsigned MAX_BINS = lsmb_pkg::MaxBinsDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  lsmb_in_if.sink                             in_i,
  lsmb_out_if.source                          out_o,
  input  logic                                cfg_we_i,
  input  logic [lsmb_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [lsmb_pkg::CfgDataW-1:0]       cfg_data_i
);

  localparam int unsigned AW = $clog2(MAX_BINS);
  localparam int unsigned CW = lsmb_pkg::CordicW;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_ANGLE = 13'b0000000000010,
    S_ROTGO = 13'b0000000000100,
    S_ROTW  = 13'b0000000001000,
    S_MUL   = 13'b0000000010000,
    S_VGO   = 13'b0000000100000,
    S_VECW  = 13'b0000001000000,
    S_RNG   = 13'b0000010000000,
    S_BIN   = 13'b0000100000000,
    S_UPD   = 13'b0001000000000,
    S_RD    = 13'b0010000000000,
    S_RDW   = 13'b0100000000000,
    S_CLR   = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [12:0] bin_count_q;
  logic [15:0] range_min_q, range_max_q, body_radius_q;
  logic [63:0] front_pose_q, back_pose_q;
  logic [31:0] front_geom_q, back_geom_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_count_q   <= 13'd720;
      range_min_q   <= 16'd0;
      range_max_q   <= 16'd30000;
      body_radius_q <= 16'd180;
      front_pose_q  <= 64'h4000000000000000;
      back_pose_q   <= 64'h4000000000000000;
      front_geom_q  <= 32'd0;
      back_geom_q   <= 32'd0;
    end else if (cfg_we_i) begin
      case (lsmb_pkg::cfg_idx_e'(cfg_idx_i))
        lsmb_pkg::CFG_BIN_COUNT:   bin_count_q   <= cfg_data_i[12:0];
        lsmb_pkg::CFG_RANGE_MIN:   range_min_q   <= cfg_data_i[15:0];
        lsmb_pkg::CFG_RANGE_MAX:   range_max_q   <= cfg_data_i[15:0];
        lsmb_pkg::CFG_BODY_RADIUS: body_radius_q <= cfg_data_i[15:0];
        lsmb_pkg::CFG_FRONT_POSE:  front_pose_q  <= cfg_data_i;
        lsmb_pkg::CFG_BACK_POSE:   back_pose_q   <= cfg_data_i;
        lsmb_pkg::CFG_FRONT_GEOM:  front_geom_q  <= cfg_data_i[31:0];
        lsmb_pkg::CFG_BACK_GEOM:   back_geom_q   <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // captured item
  logic        kind_q, sensor_q;
  logic [11:0] idx_q, read_bin_q;
  logic [15:0] r_q;

  // datapath registers
  logic [15:0]                angle_q;
  logic                       flip_q;
  logic signed [17:0]         c_q, s_q;
  logic signed [35:0]         px_q, py_q;
  logic signed [47:0]         accx_q, accy_q;
  logic [2:0]                 mstep_q;
  logic [22:0]                rng_q;
  logic [15:0]                bearing_q;
  logic [AW-1:0]              bin_q;
  logic [AW-1:0]              clr_q;

  // result register
  logic        out_valid_q;
  logic [11:0] out_bin_q;
  logic [15:0] out_rng_q;
  logic        out_empty_q;

  // sensor selected pose and geometry
  logic [63:0] pose;
  logic [31:0] geom;
  logic signed [15:0] pc, ps, tx, ty;
  assign pose = sensor_q ? back_pose_q : front_pose_q;
  assign geom = sensor_q ? back_geom_q : front_geom_q;
  assign pc = pose[63:48];
  assign ps = pose[47:32];
  assign tx = pose[31:16];
  assign ty = pose[15:0];

  // clamped bin count
  logic [16:0] active;
  always_comb begin
    if (bin_count_q == 13'd0) begin
      active = 17'd1;
    end else if ({4'd0, bin_count_q} > 17'(MAX_BINS)) begin
      active = 17'(MAX_BINS);
    end else begin
      active = {4'd0, bin_count_q};
    end
  end

  // cordic unit
  lsmb_pkg::cordic_ctl_t   cctl;
  logic signed [CW-1:0]    cx_in, cy_in, cx_out, cy_out;
  logic signed [17:0]      cz_in, cz_out;
  logic                    cdone;

  lsmb_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (cctl),
    .x_i    (cx_in),
    .y_i    (cy_in),
    .z_i    (cz_in),
    .done_o (cdone),
    .x_o    (cx_out),
    .y_o    (cy_out),
    .z_o    (cz_out)
  );

  // folding of the sample angle into +-quarter turn
  logic signed [17:0] zraw, zfold;
  logic               fold;
  always_comb begin
    zraw = {{2{angle_q[15]}}, angle_q};
    fold = 1'b0;
    zfold = zraw;
    if (zraw > 18'sd16384) begin
      zfold = zraw - 18'sd32768;
      fold  = 1'b1;
    end else if (zraw < -18'sd16384) begin
      zfold = zraw + 18'sd32768;
      fold  = 1'b1;
    end
  end

  // base frame point, right half plane for vectoring
  logic signed [CW-1:0] bx, by;
  assign bx = {{6{accx_q[47]}}, accx_q[47:14]} + {{10{tx[15]}}, tx, 14'd0};
  assign by = {{6{accy_q[47]}}, accy_q[47:14]} + {{10{ty[15]}}, ty, 14'd0};

  always_comb begin
    cctl  = '0;
    cx_in = CW'(lsmb_pkg::InvGainQ14);
    cy_in = '0;
    cz_in = zfold;
    if (state_q == S_ROTGO) begin
      cctl.start = 1'b1;
    end else if (state_q == S_VGO) begin
      cctl.start = 1'b1;
      cctl.vec   = 1'b1;
      if (bx[CW-1]) begin
        cx_in = -bx;
        cy_in = -by;
        cz_in = 18'sd32768;
      end else begin
        cx_in = bx;
        cy_in = by;
        cz_in = '0;
      end
    end
  end

  // shared multiplier for the point and pose products
  logic signed [35:0] ma;
  logic signed [17:0] mb;
  logic signed [53:0] mp;
  always_comb begin
    case (mstep_q)
      3'd0:    begin ma = {{18{c_q[17]}}, c_q}; mb = {2'b00, r_q}; end
      3'd1:    begin ma = {{18{s_q[17]}}, s_q}; mb = {2'b00, r_q}; end
      3'd2:    begin ma = px_q; mb = {{2{pc[15]}}, pc}; end
      3'd3:    begin ma = py_q; mb = {{2{ps[15]}}, ps}; end
      3'd4:    begin ma = px_q; mb = {{2{ps[15]}}, ps}; end
      default: begin ma = py_q; mb = {{2{pc[15]}}, pc}; end
    endcase
    mp = ma * mb;
  end

  // base range from the vectoring magnitude
  logic [52:0] rprod;
  assign rprod = 53'(cx_out[36:0]) * 53'(lsmb_pkg::InvGainQ16) + 53'(32'd536870912);

  // sector of the bearing
  logic [15:0] bshift;
  logic [32:0] bprod;
  assign bshift = bearing_q + 16'h8000;
  assign bprod  = {17'd0, bshift} * {16'd0, active};

  logic drop;
  assign drop = (rng_q < {7'd0, body_radius_q}) || (rng_q < {7'd0, range_min_q}) ||
                (rng_q > {7'd0, range_max_q});

  // bin memory
  logic                 mrd_en, mwr_en;
  logic [AW-1:0]        mrd_addr, mwr_addr;
  lsmb_pkg::bin_entry_t mrd_data, mwr_data;

  lsmb_bin_mem #(
    .DEPTH (MAX_BINS),
    .AW    (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .rd_en_i   (mrd_en),
    .rd_addr_i (mrd_addr),
    .rd_data_o (mrd_data),
    .wr_en_i   (mwr_en),
    .wr_addr_i (mwr_addr),
    .wr_data_i (mwr_data)
  );

  // read path decisions
  logic        rd_inrange, rd_filled, out_slot;
  logic [16:0] marker_sum;
  logic [15:0] marker;
  assign rd_inrange = {5'd0, read_bin_q} < 17'(MAX_BINS);
  assign rd_filled  = rd_inrange && ({5'd0, read_bin_q} < active) && mrd_data.filled;
  assign marker_sum = {1'b0, range_max_q} + 17'(lsmb_pkg::EmptyMarginMm);
  assign marker     = marker_sum[16] ? 16'hFFFF : marker_sum[15:0];
  assign out_slot   = !out_valid_q || out_o.ready;

  logic upd_take;
  assign upd_take = !mrd_data.filled || (rng_q[15:0] < mrd_data.min_range);

  always_comb begin
    mrd_en   = 1'b0;
    mrd_addr = bin_q;
    mwr_en   = 1'b0;
    mwr_addr = bin_q;
    mwr_data = '0;
    case (state_q)
      S_BIN: begin
        mrd_en   = !drop;
        mrd_addr = AW'(bprod[32:16]);
      end
      S_RD: begin
        mrd_en   = rd_inrange;
        mrd_addr = AW'(read_bin_q);
      end
      S_UPD: begin
        mwr_en   = upd_take;
        mwr_data = '{filled: 1'b1, min_range: rng_q[15:0]};
      end
      S_RDW: begin
        mwr_en   = out_slot && rd_inrange;
        mwr_addr = AW'(read_bin_q);
      end
      S_CLR: begin
        mwr_en   = 1'b1;
        mwr_addr = clr_q;
      end
      default: ;
    endcase
  end

  assign in_i.ready = (state_q == S_IDLE);

  logic in_take;
  assign in_take = in_i.valid && in_i.ready;

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_take) begin
          if (in_i.kind) begin
            state_d = S_RD;
          end else if (in_i.range_valid &&
                       ({5'd0, in_i.sample_index} < 17'(lsmb_pkg::MaxSamples))) begin
            state_d = S_ANGLE;
          end
        end
      end
      S_ANGLE: state_d = S_ROTGO;
      S_ROTGO: state_d = S_ROTW;
      S_ROTW:  if (cdone) state_d = S_MUL;
      S_MUL:   if (mstep_q == 3'd5) state_d = S_VGO;
      S_VGO:   state_d = S_VECW;
      S_VECW:  if (cdone) state_d = S_RNG;
      S_RNG:   state_d = S_BIN;
      S_BIN:   state_d = drop ? S_IDLE : S_UPD;
      S_UPD:   state_d = S_IDLE;
      S_RD:    state_d = S_RDW;
      S_RDW:   if (out_slot) state_d = S_IDLE;
      S_CLR:   if (clr_q == AW'(MAX_BINS - 1)) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      mstep_q     <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLR) begin
        clr_q <= clr_q + AW'(1);
      end
      if (state_q == S_MUL) begin
        mstep_q <= mstep_q + 3'd1;
      end else begin
        mstep_q <= 3'd0;
      end
      if (state_q == S_RDW && out_slot) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      kind_q     <= in_i.kind;
      sensor_q   <= in_i.sensor;
      idx_q      <= in_i.sample_index;
      r_q        <= in_i.range_mm;
      read_bin_q <= in_i.read_bin;
    end
    if (state_q == S_ANGLE) begin
      angle_q <= geom[31:16] + 16'(idx_q * geom[15:0]);
    end
    if (state_q == S_ROTGO) begin
      flip_q <= fold;
    end
    if (state_q == S_ROTW && cdone) begin
      c_q <= flip_q ? -cx_out[17:0] : cx_out[17:0];
      s_q <= flip_q ? -cy_out[17:0] : cy_out[17:0];
    end
    if (state_q == S_MUL) begin
      case (mstep_q)
        3'd0:    px_q   <= mp[35:0];
        3'd1:    py_q   <= mp[35:0];
        3'd2:    accx_q <= mp[47:0];
        3'd3:    accx_q <= accx_q - mp[47:0];
        3'd4:    accy_q <= mp[47:0];
        default: accy_q <= accy_q + mp[47:0];
      endcase
    end
    if (state_q == S_RNG) begin
      rng_q     <= rprod[52:30];
      bearing_q <= cz_out[15:0];
    end
    if (state_q == S_BIN) begin
      bin_q <= AW'(bprod[32:16]);
    end
    if (state_q == S_RDW && out_slot) begin
      out_bin_q   <= read_bin_q;
      out_rng_q   <= rd_filled ? mrd_data.min_range : marker;
      out_empty_q <= !rd_filled;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.bin_number   = out_bin_q;
  assign out_o.bin_range_mm = out_rng_q;
  assign out_o.bin_empty    = out_empty_q;

  // no item taken during the clearing pass
  a_clr_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLR) |-> !in_i.ready)
    else $error("item accepted during clearing pass");

  // a new result only comes out of the read step
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_RDW))
    else $error("result raised outside read step");

  // the cordic unit only finishes while the sequencer waits for it
  a_cordic_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cdone |-> (state_q == S_ROTW || state_q == S_VECW))
    else $error("cordic done while not waiting");

  // a bin update is always preceded by its memory read
  a_upd_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD) |-> $past(mrd_en))
    else $error("bin update without read");

  // kind of the captured item matches the branch taken
  a_kind_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD) |-> kind_q)
    else $error("read step for a sample item");

endmodule

// File: tb/lsmb_scoreboard.sv
`timescale 1ns / 1ps
// bin predictor and result checker for the laser scan merge binner
module lsmb_scoreboard (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  lsmb_in_if                            in_mon,
  lsmb_out_if                           out_mon,
  input  logic                          cfg_we_i,
  input  logic [lsmb_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lsmb_pkg::CfgDataW-1:0] cfg_data_i,
  output int                            fail_cnt_o,
  output int                            pending_o,
  output int                            hits_o
);

  typedef struct {
    logic [11:0] bin_number;
    logic [15:0] bin_range_mm;
    logic        bin_empty;
  } bin_report_t;

  bin_report_t report_q[$];

  logic [12:0] bin_count;
  logic [15:0] win_lo, win_hi, body_radius;
  logic [63:0] pose_reg [2];
  logic [31:0] geom_reg [2];
  bit          filled [lsmb_pkg::MaxBinsDefault];
  logic [15:0] min_range [lsmb_pkg::MaxBinsDefault];

  assign pending_o = report_q.size();

  function automatic longint arc(input int i);
    longint t[14] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1};
    return t[i];
  endfunction

  function automatic longint active_bins();
    if (bin_count == 0) return 1;
    if (bin_count > lsmb_pkg::MaxBinsDefault) return longint'(lsmb_pkg::MaxBinsDefault);
    return longint'(bin_count);
  endfunction

  // rotation mode, angle folded into +-quarter turn
  function automatic void sin_cos(input logic [15:0] ang, output longint c, output longint s);
    longint z, x, y, nx;
    bit flip;
    z = longint'($signed(ang));
    x = longint'(lsmb_pkg::InvGainQ14);
    y = 0;
    flip = 0;
    if (z > 16384) begin
      z -= 32768;
      flip = 1;
    end else if (z < -16384) begin
      z += 32768;
      flip = 1;
    end
    for (int i = 0; i < lsmb_pkg::CordicSteps; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= arc(i);
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += arc(i);
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // vectoring mode, left half plane starts at a half turn
  function automatic void to_polar(input longint xi, input longint yi,
                                   output longint rng, output logic [15:0] bearing);
    longint x, y, z, nx;
    x = xi;
    y = yi;
    z = 0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32768;
    end
    for (int i = 0; i < lsmb_pkg::CordicSteps; i++) begin
      if (y < 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= arc(i);
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += arc(i);
      end
      x = nx;
    end
    rng = (x * longint'(lsmb_pkg::InvGainQ16) + (longint'(1) << 29)) >>> 30;
    bearing = z[15:0];
  endfunction

  function automatic void merge_sample(input logic snd, input logic [11:0] idx,
                                       input logic [15:0] r);
    logic [63:0] pose;
    logic [31:0] g, a32;
    logic [15:0] bearing, sh;
    longint c, s, px, py, pc, ps, bx, by, rb, bin;
    pose = pose_reg[snd];
    g = geom_reg[snd];
    a32 = {16'd0, g[31:16]} + {20'd0, idx} * {16'd0, g[15:0]};
    sin_cos(a32[15:0], c, s);
    px = longint'(r) * c;
    py = longint'(r) * s;
    pc = longint'($signed(pose[63:48]));
    ps = longint'($signed(pose[47:32]));
    bx = ((pc * px - ps * py) >>> 14) + longint'($signed(pose[31:16])) * 16384;
    by = ((ps * px + pc * py) >>> 14) + longint'($signed(pose[15:0])) * 16384;
    to_polar(bx, by, rb, bearing);
    if (rb < body_radius || rb < win_lo || rb > win_hi) return;
    sh = bearing + 16'd32768;
    bin = (longint'(sh) * active_bins()) >> 16;
    if (!filled[bin] || rb < min_range[bin]) begin
      min_range[bin] = rb[15:0];
      filled[bin] = 1;
    end
    hits_o++;
  endfunction

  function automatic bin_report_t read_clear(input logic [11:0] rbin);
    bin_report_t rep;
    logic [16:0] marker;
    marker = 17'({1'b0, win_hi} + lsmb_pkg::EmptyMarginMm);
    rep.bin_number = rbin;
    rep.bin_range_mm = marker[16] ? 16'hFFFF : marker[15:0];
    rep.bin_empty = 1'b1;
    if (rbin < active_bins() && filled[rbin]) begin
      rep.bin_empty = 1'b0;
      rep.bin_range_mm = min_range[rbin];
    end
    filled[rbin] = 0;
    return rep;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    bin_report_t want;
    if (!rst_ni) begin
      bin_count = 13'd720;
      win_lo = 16'd0;
      win_hi = 16'd30000;
      body_radius = 16'd180;
      pose_reg[0] = 64'h4000_0000_0000_0000;
      pose_reg[1] = 64'h4000_0000_0000_0000;
      geom_reg[0] = '0;
      geom_reg[1] = '0;
      foreach (filled[i]) filled[i] = 0;
      fail_cnt_o = 0;
      hits_o = 0;
      report_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (lsmb_pkg::cfg_idx_e'(cfg_idx_i))
          lsmb_pkg::CFG_BIN_COUNT:   bin_count = cfg_data_i[12:0];
          lsmb_pkg::CFG_RANGE_MIN:   win_lo = cfg_data_i[15:0];
          lsmb_pkg::CFG_RANGE_MAX:   win_hi = cfg_data_i[15:0];
          lsmb_pkg::CFG_BODY_RADIUS: body_radius = cfg_data_i[15:0];
          lsmb_pkg::CFG_FRONT_POSE:  pose_reg[0] = cfg_data_i;
          lsmb_pkg::CFG_BACK_POSE:   pose_reg[1] = cfg_data_i;
          lsmb_pkg::CFG_FRONT_GEOM:  geom_reg[0] = cfg_data_i[31:0];
          lsmb_pkg::CFG_BACK_GEOM:   geom_reg[1] = cfg_data_i[31:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.kind) report_q.push_back(read_clear(in_mon.read_bin));
        else if (in_mon.range_valid)
          merge_sample(in_mon.sensor, in_mon.sample_index, in_mon.range_mm);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (report_q.size() == 0) begin
          fail_cnt_o++;
          if (fail_cnt_o <= 10)
            $display("unexpected bin report: bin %0d range %0d empty %0d",
                     out_mon.bin_number, out_mon.bin_range_mm, out_mon.bin_empty);
        end else begin
          want = report_q.pop_front();
          if (out_mon.bin_number !== want.bin_number ||
              out_mon.bin_range_mm !== want.bin_range_mm ||
              out_mon.bin_empty !== want.bin_empty) begin
            fail_cnt_o++;
            if (fail_cnt_o <= 10)
              $display("bin report mismatch: exp bin %0d range %0d empty %0d, got %0d %0d %0d",
                       want.bin_number, want.bin_range_mm, want.bin_empty,
                       out_mon.bin_number, out_mon.bin_range_mm, out_mon.bin_empty);
          end
        end
      end
    end
  end

endmodule

// File: tb/tb_laser_scan_merge_binner.sv
`timescale 1ns / 1ps
// stimulus and verdict for the laser scan merge binner
module tb_laser_scan_merge_binner;

  localparam int CycleLimit = 1_000_000;
  localparam int SettleCycles = 60;

  logic                          clk_i = 0;
  logic                          rst_ni = 0;
  logic                          cfg_we_i = 0;
  logic [lsmb_pkg::CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [lsmb_pkg::CfgDataW-1:0] cfg_data_i = '0;
  int                            fail_cnt, pending, hits;
  int                            cycles = 0;
  int                            samples_sent = 0, reads_sent = 0;
  int                            cur_bins = 720;

  lsmb_in_if  in_ch ();
  lsmb_out_if out_ch ();

  laser_scan_merge_binner u_dut (
    .clk_i, .rst_ni, .in_i(in_ch), .out_o(out_ch), .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  lsmb_scoreboard u_sb (
    .clk_i, .rst_ni, .in_mon(in_ch), .out_mon(out_ch), .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .fail_cnt_o(fail_cnt), .pending_o(pending), .hits_o(hits)
  );

  always #5 clk_i = ~clk_i;

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // result side back-pressure, with whole windows of ready held high
  initial begin
    int g;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
      g = gap_len();
      if (g > 0) begin
        out_ch.ready <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
    end
  end

  // drive one item; valid stays high into the next item when there is no gap
  task automatic send_item(input logic kind, input logic snd, input logic [11:0] idx,
                           input logic [15:0] rng, input logic rvalid, input logic [11:0] rbin);
    logic rdy;
    int g;
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    in_ch.sensor <= snd;
    in_ch.sample_index <= idx;
    in_ch.range_mm <= rng;
    in_ch.range_valid <= rvalid;
    in_ch.read_bin <= rbin;
    do begin
      @(negedge clk_i);
      rdy = in_ch.ready;
      @(posedge clk_i);
    end while (!rdy);
    if (kind) reads_sent++;
    else samples_sent++;
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input lsmb_pkg::cfg_idx_e idx, input logic [63:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == lsmb_pkg::CFG_BIN_COUNT)
      cur_bins = (data[12:0] == 0) ? 1 : (data[12:0] > 4096) ? 4096 : int'(data[12:0]);
  endtask

  task automatic set_window(input logic [15:0] rmin, input logic [15:0] rmax,
                            input logic [15:0] body);
    write_reg(lsmb_pkg::CFG_RANGE_MIN, {48'd0, rmin});
    write_reg(lsmb_pkg::CFG_RANGE_MAX, {48'd0, rmax});
    write_reg(lsmb_pkg::CFG_BODY_RADIUS, {48'd0, body});
  endtask

  task automatic random_geometry();
    write_reg(lsmb_pkg::CFG_FRONT_GEOM, {$urandom(), 32'd0} >> 32);
    write_reg(lsmb_pkg::CFG_BACK_GEOM,
              {32'd0, 16'($urandom()), 16'($urandom_range(1, 64))});
  endtask

  // mostly landing samples and reads of live bins, a share of raw noise
  task automatic random_items(input int n);
    int p;
    logic [11:0] rb;
    for (int k = 0; k < n; k++) begin
      p = $urandom_range(0, 99);
      if (k == n / 2) drain();    // let the block run dry once per phase
      if (p < 50)
        send_item(1'b0, 1'($urandom_range(0, 1)), 12'($urandom()),
                  16'($urandom_range(150, 6000)), 1'b1, 12'($urandom()));
      else if (p < 60)
        send_item(1'b0, 1'($urandom()), 12'($urandom()), 16'($urandom()), 1'($urandom()),
                  12'($urandom()));
      else begin
        rb = ($urandom_range(0, 9) == 0) ? 12'($urandom()) : 12'($urandom_range(0, cur_bins - 1));
        send_item(1'b1, 1'($urandom()), 12'($urandom()), 16'($urandom()), 1'($urandom()), rb);
      end
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.kind = 1'b0;
    in_ch.sensor = 1'b0;
    in_ch.sample_index = '0;
    in_ch.range_mm = '0;
    in_ch.range_valid = 1'b0;
    in_ch.read_bin = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: field extremes, invalid sample, both sensors, out of range reads
    send_item(1'b0, 1'b0, 12'd0, 16'd1000, 1'b1, 12'd0);
    send_item(1'b0, 1'b1, 12'd4095, 16'd2000, 1'b1, 12'hFFF);
    send_item(1'b0, 1'b0, 12'd10, 16'd65535, 1'b1, 12'd0);
    send_item(1'b0, 1'b0, 12'd20, 16'd0, 1'b1, 12'd0);
    send_item(1'b0, 1'b1, 12'd30, 16'd500, 1'b0, 12'd0);
    send_item(1'b0, 1'b0, 12'd5, 16'd100, 1'b1, 12'd0);
    send_item(1'b1, 1'b0, 12'd0, 16'd0, 1'b0, 12'd360);
    send_item(1'b1, 1'b1, 12'hFFF, 16'hFFFF, 1'b1, 12'd360);
    send_item(1'b1, 1'b0, 12'd0, 16'd0, 1'b0, 12'd0);
    send_item(1'b1, 1'b0, 12'd0, 16'd0, 1'b0, 12'd719);
    send_item(1'b1, 1'b0, 12'd0, 16'd0, 1'b0, 12'd720);
    send_item(1'b1, 1'b0, 12'd0, 16'd0, 1'b0, 12'd4095);
    drain();

    write_reg(lsmb_pkg::CFG_FRONT_GEOM, {32'd0, 16'hC000, 16'd91});
    write_reg(lsmb_pkg::CFG_BACK_GEOM, {32'd0, 16'h4000, 16'd91});
    write_reg(lsmb_pkg::CFG_BACK_POSE, {-16'sd16384, 16'sd0, -16'sd200, 16'sd0});
    random_items(180);
    drain();

    // one bin over the whole turn, the widest window, rotated poses
    write_reg(lsmb_pkg::CFG_BIN_COUNT, 64'd1);
    set_window(16'd0, 16'd64535, 16'd0);
    write_reg(lsmb_pkg::CFG_FRONT_POSE, {16'sd0, 16'sd16384, 16'sd100, -16'sd50});
    random_geometry();
    random_items(170);
    drain();

    // largest bin count, arbitrary pose patterns
    write_reg(lsmb_pkg::CFG_BIN_COUNT, 64'd4096);
    set_window(16'd0, 16'd30000, 16'd180);
    write_reg(lsmb_pkg::CFG_FRONT_POSE, {$urandom(), $urandom()});
    write_reg(lsmb_pkg::CFG_BACK_POSE, {$urandom(), $urandom()});
    random_geometry();
    random_items(170);
    drain();

    // zero bin count clamps to one; crossed window drops everything
    write_reg(lsmb_pkg::CFG_BIN_COUNT, 64'd0);
    set_window(16'd5000, 16'd1000, 16'd0);
    random_items(150);
    drain();

    // oversized bin count clamps; body radius at its top
    write_reg(lsmb_pkg::CFG_BIN_COUNT, 64'h1FFF);
    set_window(16'd0, 16'd64535, 16'hFFFF);
    random_items(150);
    drain();

    // typical scanner setup with offset mounts
    write_reg(lsmb_pkg::CFG_BIN_COUNT, 64'($urandom_range(2, 400)));
    set_window(16'($urandom_range(0, 300)), 16'($urandom_range(7000, 20000)),
               16'($urandom_range(0, 400)));
    write_reg(lsmb_pkg::CFG_FRONT_POSE, {16'sd11585, 16'sd11585, 16'sd300, 16'sd120});
    write_reg(lsmb_pkg::CFG_BACK_POSE, {-16'sd11585, 16'sd11585, -16'sd300, -16'sd120});
    random_geometry();
    random_items(250);
    drain();

    write_reg(lsmb_pkg::CFG_BIN_COUNT, 64'($urandom_range(16, 720)));
    set_window(16'd0, 16'd64535, 16'd0);
    random_items(250);
    drain();

    $display("sent %0d samples and %0d reads over seven register settings", samples_sent,
             reads_sent);
    $display("%0d samples landed in a bin", hits);
    if (fail_cnt == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d reports missing", fail_cnt, pending);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/lsmb_pkg.sv
hdl/lsmb_if.sv
hdl/lsmb_cordic.sv
hdl/lsmb_bin_mem.sv
hdl/laser_scan_merge_binner.sv
tb/lsmb_scoreboard.sv
tb/tb_laser_scan_merge_binner.sv
